>>> src/arr_pkg.sv
`timescale 1ns / 1ps

package arr_pkg;

  localparam int unsigned RING_DEPTH  = 8192;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned FRAME_W     = 2 * SAMPLE_W;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned POS_W       = 64;
  localparam int unsigned STEP_W      = 34;
  localparam int unsigned LVL_W       = 14;
  localparam int unsigned ERR_SHIFT   = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [STEP_W-1:0] NOMINAL_STEP_RST = 34'h1_0000_0000;
  localparam logic [LVL_W-1:0]  TARGET_LEVEL_RST = 14'd1024;
  localparam logic [LVL_W-1:0]  LVL_MAX          = '1;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_BATCH   = 2'd1,
    KIND_PRODUCE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_BATCH,
    OP_PRODUCE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOMINAL_STEP = 1'b0,
    CFG_TARGET_LEVEL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       starved;
    logic [LVL_W-1:0]           fill_level;
  } out_item_t;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } op_item_t;

endpackage

>>> src/arr_ram.sv
`timescale 1ns / 1ps

module arr_ram #(
  parameter int unsigned Width = arr_pkg::FRAME_W,
  parameter int unsigned Depth = arr_pkg::RING_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/arr_front.sv
`timescale 1ns / 1ps

module arr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  arr_pkg::in_item_t in_data_i,
  output logic              q_valid_o,
  output arr_pkg::op_item_t q_data_o,
  input  logic              q_pop_i
);

  import arr_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  op_item_t        slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            keep;
  op_e             op;
  logic            push;
  logic            pop;

  always_comb begin
    keep = 1'b1;
    op   = OP_PUSH;
    case (kind_e'(in_data_i.kind))
      KIND_PUSH:    op = OP_PUSH;
      KIND_BATCH:   op = OP_BATCH;
      KIND_PRODUCE: op = OP_PRODUCE;
      default:      keep = 1'b0;
    endcase
  end

  assign in_ready_o = (cnt_q != (PtrW + 1)'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = slot_q[rptr_q];
  assign push       = in_valid_i && in_ready_o && keep;
  assign pop        = q_pop_i && q_valid_o;

  assign wptr_d = push ? wptr_q + PtrW'(1) : wptr_q;
  assign rptr_d = pop ? rptr_q + PtrW'(1) : rptr_q;
  assign cnt_d  = cnt_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= '{op: op, left: in_data_i.left_in, right: in_data_i.right_in};
    end
  end

endmodule

>>> src/arr_back.sv
`timescale 1ns / 1ps

module arr_back #(
  parameter int unsigned RingDepth = arr_pkg::RING_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  arr_pkg::op_item_t               q_data_i,
  output logic                            q_pop_o,
  input  logic                            cfg_valid_i,
  input  logic [arr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [arr_pkg::STEP_W-1:0]      cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output arr_pkg::out_item_t              out_data_o
);

  import arr_pkg::*;

  localparam int unsigned AddrW    = $clog2(RingDepth);
  localparam int unsigned ModShift = COUNT_W + AddrW;
  localparam int unsigned ProdW    = 2 * COUNT_W + 1;
  localparam logic [ProdW-1:0] ModMulFull =
    ((ProdW'(1) << ModShift) + ProdW'(RingDepth) - ProdW'(1)) / ProdW'(RingDepth);
  localparam logic [COUNT_W:0]   ModMul    = ModMulFull[COUNT_W:0];
  localparam logic [COUNT_W-1:0] DepthC    = COUNT_W'(RingDepth);
  localparam logic [COUNT_W-1:0] DropLevel = COUNT_W'(RingDepth - 2);
  localparam logic [AddrW-1:0]   LastSlot  = AddrW'(RingDepth - 1);
  localparam int unsigned DiffW  = SAMPLE_W + 1;
  localparam int unsigned LerpW  = DiffW + COUNT_W + 1;
  localparam int unsigned ErrW   = COUNT_W + 2;

  typedef struct packed {
    logic               wr;
    logic               rd;
    logic               starved;
    logic [COUNT_W-1:0] num;
    logic               num_max;
    logic [COUNT_W-1:0] frac;
    logic [FRAME_W-1:0] frame;
    logic [LVL_W-1:0]   fill;
  } pipe_t;

  // architectural state
  logic [COUNT_W-1:0] wc_q, wc_d;
  logic [COUNT_W-1:0] rc_q, rc_d;
  logic [POS_W-1:0]   rp_q, rp_d;
  logic [POS_W-1:0]   step_q, step_d;
  logic [STEP_W-1:0]  nom_q, nom_d;
  logic [LVL_W-1:0]   tgt_q, tgt_d;

  // pipeline
  logic [4:0]         vld_q, vld_d;
  pipe_t              p1_q, p2_q, p3_q, p4_q, p5_q;
  pipe_t              iss;
  logic [ProdW-1:0]   mprod_q, mprod_d;
  logic [COUNT_W-1:0] qd_q, qd_d;
  logic [COUNT_W-1:0] quot;
  logic signed [SAMPLE_W-1:0] s0l_q, s0l_d, s0r_q, s0r_d;
  logic signed [LerpW-1:0]    pl_q, pl_d, pr_q, pr_d;
  out_item_t          out_q, out_d;
  logic               out_vld_q, out_vld_d;
  logic               adv;

  // issue
  logic [COUNT_W-1:0] fill_cur;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] nxt;
  logic [COUNT_W-1:0] rc_new;
  logic [COUNT_W-1:0] fill_new;
  logic signed [ErrW-1:0] fill_s, tgt_s, err_raw, err_clip;
  logic [POS_W-1:0]   err_ext;
  logic [POS_W-1:0]   step_new;

  // memory
  logic [COUNT_W-1:0] rem;
  logic [AddrW-1:0]   slot_a, slot_b;
  logic [FRAME_W-1:0] rd_a, rd_b;
  logic signed [SAMPLE_W-1:0] s1l, s1r;
  logic signed [DiffW-1:0]    diffl, diffr;

  assign adv     = !out_vld_q || out_ready_i;
  assign q_pop_o = q_valid_i && adv;

  assign fill_cur = wc_q - rc_q;
  assign idx      = rp_q[POS_W-1:COUNT_W];
  assign nxt      = idx + COUNT_W'(1);

  always_comb begin
    rc_new = rc_q;
    if (idx > rc_q) begin
      rc_new = (idx > wc_q) ? wc_q : idx;
    end
  end

  assign fill_new = wc_q - rc_new;
  assign fill_s   = $signed(ErrW'(fill_new));
  assign tgt_s    = $signed(ErrW'(tgt_q));
  assign err_raw  = fill_s - tgt_s;

  always_comb begin
    err_clip = err_raw;
    if (err_raw > tgt_s) begin
      err_clip = tgt_s;
    end else if (err_raw < -tgt_s) begin
      err_clip = -tgt_s;
    end
  end

  assign err_ext  = POS_W'(err_clip);
  assign step_new = POS_W'(nom_q) + (err_ext << ERR_SHIFT);

  always_comb begin
    wc_d   = wc_q;
    rc_d   = rc_q;
    rp_d   = rp_q;
    step_d = step_q;
    iss         = '0;
    iss.num     = idx;
    iss.num_max = &idx;
    iss.frac    = rp_q[COUNT_W-1:0];
    iss.frame   = {q_data_i.right, q_data_i.left};
    iss.fill    = (fill_cur > COUNT_W'(LVL_MAX)) ? LVL_MAX : fill_cur[LVL_W-1:0];
    if (q_pop_o) begin
      case (q_data_i.op)
        OP_PUSH: begin
          if (fill_cur < DropLevel) begin
            wc_d    = wc_q + COUNT_W'(1);
            iss.wr  = 1'b1;
            iss.num = wc_q;
          end
        end
        OP_BATCH: begin
          rc_d   = rc_new;
          step_d = step_new;
        end
        OP_PRODUCE: begin
          iss.rd = 1'b1;
          if (nxt >= wc_q) begin
            iss.starved = 1'b1;
          end else begin
            rp_d = rp_q + step_q;
          end
        end
        default: iss.rd = 1'b0;
      endcase
    end
  end

  always_comb begin
    nom_d = nom_q;
    tgt_d = tgt_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_NOMINAL_STEP: nom_d = cfg_data_i;
        CFG_TARGET_LEVEL: tgt_d = cfg_data_i[LVL_W-1:0];
        default:          nom_d = nom_q;
      endcase
    end
  end

  // slot = count mod depth by reciprocal multiply
  assign mprod_d = ProdW'(p1_q.num) * ProdW'(ModMul);
  assign quot    = COUNT_W'(mprod_q >> ModShift);
  assign qd_d    = quot * DepthC;

  assign rem    = p3_q.num - qd_q;
  assign slot_a = rem[AddrW-1:0];
  assign slot_b = (p3_q.num_max || slot_a == LastSlot) ? '0 : slot_a + AddrW'(1);

  arr_ram #(
    .Width (FRAME_W),
    .Depth (RingDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (vld_q[2] && p3_q.wr && adv),
    .waddr_i   (slot_a),
    .wdata_i   (p3_q.frame),
    .re_i      (adv),
    .raddr_a_i (slot_a),
    .raddr_b_i (slot_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign s0l_d = rd_a[SAMPLE_W-1:0];
  assign s0r_d = rd_a[FRAME_W-1:SAMPLE_W];
  assign s1l   = rd_b[SAMPLE_W-1:0];
  assign s1r   = rd_b[FRAME_W-1:SAMPLE_W];
  assign diffl = DiffW'(s1l) - DiffW'(s0l_d);
  assign diffr = DiffW'(s1r) - DiffW'(s0r_d);
  assign pl_d  = diffl * $signed({1'b0, p4_q.frac});
  assign pr_d  = diffr * $signed({1'b0, p4_q.frac});

  always_comb begin
    out_d            = out_q;
    out_vld_d        = out_vld_q;
    if (adv) begin
      out_vld_d          = vld_q[4] && p5_q.rd;
      out_d.starved      = p5_q.starved;
      out_d.fill_level   = p5_q.fill;
      out_d.left_out     = '0;
      out_d.right_out    = '0;
      if (!p5_q.starved) begin
        out_d.left_out  = s0l_q + pl_q[COUNT_W +: SAMPLE_W];
        out_d.right_out = s0r_q + pr_q[COUNT_W +: SAMPLE_W];
      end
    end
  end

  assign vld_d = adv ? {vld_q[3:0], q_pop_o} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q      <= '0;
      rc_q      <= '0;
      rp_q      <= '0;
      step_q    <= '0;
      nom_q     <= NOMINAL_STEP_RST;
      tgt_q     <= TARGET_LEVEL_RST;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      wc_q      <= wc_d;
      rc_q      <= rc_d;
      rp_q      <= rp_d;
      step_q    <= step_d;
      nom_q     <= nom_d;
      tgt_q     <= tgt_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (adv) begin
      p1_q    <= iss;
      p2_q    <= p1_q;
      p3_q    <= p2_q;
      p4_q    <= p3_q;
      p5_q    <= p4_q;
      mprod_q <= mprod_d;
      qd_q    <= qd_d;
      s0l_q   <= s0l_d;
      s0r_q   <= s0r_d;
      pl_q    <= pl_d;
      pr_q    <= pr_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> src/audio_ring_resampler.sv
`timescale 1ns / 1ps

// Stereo ring buffer with a linear-interpolating rate converter.
// in channel: one item per transfer; kind selects push frame, begin batch
//   or produce frame. Kind 3 is taken and ignored.
// out channel: one result per produce item, in order: interpolated left and
//   right samples, starved flag, ring fill level.
// cfg channel: always ready; index 0 nominal step (2.32), index 1 target
//   fill level. Write only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall, set by
//   the issue stage that updates the counters and read position; the sample
//   memory is read at two slots per cycle through a dual-read RAM.
// Path: a produce result passes from its input transfer through the queue,
//   issue, two slot-multiply stages, RAM read, interpolation multiply and
//   output register.
// A 4-entry queue keeps in_ready_o independent of out_ready_i; while the
//   receiver stalls the back pipeline holds and the queue fills, then
//   in_ready_o drops.
// Reset clears counters, position and batch step, and loads default
//   configuration; ring contents are undefined until pushed.

module audio_ring_resampler #(
  parameter int unsigned RingDepth = arr_pkg::RING_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  arr_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output arr_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [arr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [arr_pkg::STEP_W-1:0]    cfg_data_i
);

  import arr_pkg::*;

  localparam int unsigned FillCap =
    (RingDepth - 2 < 2 ** LVL_W - 1) ? RingDepth - 2 : 2 ** LVL_W - 1;

  logic     q_valid;
  logic     q_pop;
  op_item_t q_data;

  assign cfg_ready_o = 1'b1;

  arr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  arr_back #(
    .RingDepth (RingDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_no_issue_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !q_pop)
    else $error("issue while output stalled");

  a_starved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.starved |->
      out_data_o.left_out == '0 && out_data_o.right_out == '0)
    else $error("starved result carries samples");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fill_level <= LVL_W'(FillCap))
    else $error("fill level beyond ring capacity");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import arr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam longint      LEVEL_GAIN    = 1024;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]    cfg_data = '0;

  // resampler state as the block should hold it
  logic [FRAME_W-1:0] ring_mem [RING_DEPTH];
  logic [COUNT_W-1:0] wr_cnt = '0;
  logic [COUNT_W-1:0] rd_cnt = '0;
  logic [POS_W-1:0]   rd_pos = '0;
  logic [POS_W-1:0]   step_cur = '0;
  logic [STEP_W-1:0]  nom_step = NOMINAL_STEP_RST;
  logic [LVL_W-1:0]   tgt_level = TARGET_LEVEL_RST;

  in_item_t  pending_q [$];
  out_item_t due_q [$];

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned items_taken = 0;
  int unsigned frames_checked = 0;
  int unsigned starved_seen = 0;
  int unsigned pushes_dropped = 0;
  int unsigned reg_writes = 0;
  int unsigned errors = 0;
  int unsigned reported = 0;

  logic      got_valid = 1'b0;
  out_item_t got_frame = '0;

  audio_ring_resampler uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] s0,
                                                input logic [SAMPLE_W-1:0] s1,
                                                input logic [31:0] frac);
    longint d;
    longint p;
    d = longint'($signed(s1)) - longint'($signed(s0));
    p = d * longint'({32'b0, frac});
    return SAMPLE_W'(longint'($signed(s0)) + (p >>> 32));
  endfunction

  task automatic resample_model(input in_item_t it);
    out_item_t   res;
    logic [31:0] fill;
    logic [31:0] idx;
    logic [31:0] nxt;
    logic [31:0] passed;
    logic [FRAME_W-1:0] a;
    logic [FRAME_W-1:0] b;
    longint err;
    longint lim;
    case (it.kind)
      KIND_PUSH: begin
        fill = wr_cnt - rd_cnt;
        if (fill < RING_DEPTH - 2) begin
          ring_mem[wr_cnt % RING_DEPTH] = {it.right_in, it.left_in};
          wr_cnt = wr_cnt + 1;
        end else begin
          pushes_dropped++;
        end
      end
      KIND_BATCH: begin
        passed = rd_pos[63:32];
        if (passed > rd_cnt) begin
          rd_cnt = passed;
          if (rd_cnt > wr_cnt) rd_cnt = wr_cnt;
        end
        fill = wr_cnt - rd_cnt;
        lim = $signed({50'b0, tgt_level});
        err = $signed({32'b0, fill}) - lim;
        if (err > lim) err = lim;
        if (err < -lim) err = -lim;
        step_cur = {30'b0, nom_step} + err * LEVEL_GAIN;
      end
      KIND_PRODUCE: begin
        idx = rd_pos[63:32];
        nxt = idx + 1;
        if (nxt >= wr_cnt) begin
          res.left_out  = '0;
          res.right_out = '0;
          res.starved   = 1'b1;
        end else begin
          a = ring_mem[idx % RING_DEPTH];
          b = ring_mem[nxt % RING_DEPTH];
          res.left_out  = blend(a[15:0], b[15:0], rd_pos[31:0]);
          res.right_out = blend(a[31:16], b[31:16], rd_pos[31:0]);
          res.starved   = 1'b0;
          rd_pos = rd_pos + step_cur;
        end
        fill = wr_cnt - rd_cnt;
        res.fill_level = (fill > LVL_MAX) ? LVL_MAX : fill[LVL_W-1:0];
        due_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resample_model(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // compare the registered copy of each transfer so the expectation is always in place
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (got_valid) begin
      if (due_q.size() == 0) begin
        errors++;
        if (reported < REPORT_LIMIT)
          $display("unexpected frame: L=%0d R=%0d starved=%0b level=%0d",
                   got_frame.left_out, got_frame.right_out, got_frame.starved,
                   got_frame.fill_level);
        reported++;
      end else begin
        want = due_q.pop_front();
        frames_checked++;
        if (got_frame.starved) starved_seen++;
        if (got_frame.left_out !== want.left_out || got_frame.right_out !== want.right_out ||
            got_frame.starved !== want.starved || got_frame.fill_level !== want.fill_level)
        begin
          errors++;
          if (reported < REPORT_LIMIT)
            $display("frame %0d mismatch: want L=%0d R=%0d starved=%0b level=%0d, got L=%0d R=%0d starved=%0b level=%0d",
                     frames_checked, want.left_out, want.right_out, want.starved,
                     want.fill_level, got_frame.left_out, got_frame.right_out,
                     got_frame.starved, got_frame.fill_level);
          reported++;
        end
      end
    end
    got_valid <= rst_n && out_valid && out_ready;
    got_frame <= out_data;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(input cfg_reg_e which, input logic [STEP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (which == CFG_NOMINAL_STEP) nom_step = value;
    else tgt_level = value[LVL_W-1:0];
    reg_writes++;
  endtask

  task automatic set_idling(input int unsigned pattern);
    case (pattern % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 69; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 69; end
      default: begin send_idle = 37; recv_stall = 37; end
    endcase
    @(negedge clk);
  endtask

  task automatic queue_item(input logic [1:0] kind, input logic [SAMPLE_W-1:0] l,
                            input logic [SAMPLE_W-1:0] r);
    in_item_t it;
    it.kind     = kind;
    it.left_in  = l;
    it.right_in = r;
    pending_q.push_back(it);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // bursts opened by a batch; a little noise of unused and random kinds
  task automatic queue_stream(input int unsigned count);
    int unsigned made;
    int unsigned roll;
    made = 0;
    while (made < count) begin
      queue_item(KIND_BATCH, pick_sample(), pick_sample());
      made++;
      repeat ($urandom_range(4, 24)) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          queue_item(KIND_UNUSED, pick_sample(), pick_sample());
        end else if (roll < 8) begin
          queue_item(2'($urandom_range(2)), pick_sample(), pick_sample());
          made++;
        end else if (roll < 52) begin
          queue_item(KIND_PUSH, pick_sample(), pick_sample());
          made++;
        end else begin
          queue_item(KIND_PRODUCE, pick_sample(), pick_sample());
          made++;
        end
      end
    end
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || in_valid || due_q.size() != 0 || got_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("timeout with %0d frames still due", due_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // default settings: produce before any frame and before any batch
    set_idling(0);
    queue_item(KIND_PRODUCE, 16'h0000, 16'h0000);
    queue_item(KIND_PUSH, 16'h7fff, 16'h8000);
    queue_item(KIND_PUSH, 16'h8000, 16'h7fff);
    queue_item(KIND_PRODUCE, 16'h0000, 16'h0000);
    queue_item(KIND_PUSH, 16'h0000, 16'hffff);
    queue_item(KIND_PUSH, 16'hffff, 16'h0000);
    queue_item(KIND_PUSH, 16'h3039, 16'hcfc7);
    queue_item(KIND_BATCH, 16'h0000, 16'h0000);
    repeat (6) queue_item(KIND_PRODUCE, 16'h0000, 16'h0000);
    queue_item(KIND_UNUSED, 16'h5a5a, 16'ha5a5);
    queue_item(KIND_BATCH, 16'hffff, 16'hffff);
    queue_item(KIND_PUSH, 16'h0001, 16'h0001);
    queue_item(KIND_PRODUCE, 16'h0000, 16'h0000);
    queue_item(KIND_PRODUCE, 16'h0000, 16'h0000);
    settle();

    // zero nominal step: steps go negative and the position slips behind the
    // retired frames; keep it short so the integer part never wraps below zero
    write_reg(CFG_NOMINAL_STEP, '0);
    write_reg(CFG_TARGET_LEVEL, STEP_W'(LVL_MAX));
    set_idling(1);
    queue_stream(120);
    settle();

    // largest step with no level feedback: retire runs up against the writes
    write_reg(CFG_NOMINAL_STEP, STEP_MAX);
    write_reg(CFG_TARGET_LEVEL, '0);
    set_idling(2);
    queue_stream(150);
    settle();

    write_reg(CFG_NOMINAL_STEP, NOMINAL_STEP_RST);
    write_reg(CFG_TARGET_LEVEL, STEP_W'(RING_DEPTH));
    set_idling(3);
    queue_stream(150);
    settle();

    for (int unsigned ph = 0; ph < 4; ph++) begin
      write_reg(CFG_NOMINAL_STEP,
                STEP_W'($urandom_range(32'h8000_0000, 32'hffff_ffff)) << $urandom_range(1));
      write_reg(CFG_TARGET_LEVEL, STEP_W'($urandom_range(RING_DEPTH)));
      set_idling(ph);
      queue_stream(160);
      settle();
    end

    errors += due_q.size();
    $display("covered %0d input transfers and %0d register writes over eight phases",
             items_taken, reg_writes);
    $display("checked %0d output frames, %0d starved, %0d pushes dropped on a full ring",
             frames_checked, starved_seen, pushes_dropped);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
